// File: rtl/core/pmbd_pkg.sv
package pmbd_pkg;

  localparam int unsigned MAIN_AW    = 16;
  localparam int unsigned BANK_W     = 4;
  localparam int unsigned WIN_AW     = 14;
  localparam int unsigned BANK_AW    = BANK_W + WIN_AW;
  localparam int unsigned MAIN_DEPTH = 1 << MAIN_AW;
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  localparam logic [7:0] MAIN_INIT = 8'h00;
  localparam logic [7:0] BANK_INIT = 8'hFF;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [15:0] ADDR_BANK_SEL_A = 16'hFE30;
  localparam logic [15:0] ADDR_BANK_SEL_B = 16'hFE34;
  localparam logic [15:0] ADDR_PALETTE    = 16'hFE21;
  localparam logic [15:0] ADDR_DISP_SEL   = 16'hFE00;
  localparam logic [15:0] ADDR_DISP_DATA  = 16'hFE01;
  localparam logic [1:0]  WIN_TAG         = 2'b10;

  localparam logic [4:0] DISP_REG_START_HIGH = 5'd12;
  localparam logic [4:0] DISP_REG_START_LOW  = 5'd13;

  typedef struct packed {
    logic               rd_en;
    logic               sel_bank;
    logic               wr_main;
    logic               wr_bank;
    logic [MAIN_AW-1:0] main_addr;
    logic [BANK_AW-1:0] bank_addr;
    logic [7:0]         wdata;
  } mem_req_t;

endpackage

// File: rtl/core/paged_memory_bus_decoder_core.sv
// Paged memory bus decoder. One bus access per beat: a 64 KB flat RAM plus sixteen
// 16 KB banks mapped at 0x8000-0xBFFF when paging is on. Each accepted beat gives one
// result beat via the s1 and output registers; a new beat can be taken every cycle
// unless the clear runs or a full pipe is stalled at the output, since the bank select,
// palette and display registers and the RAM read register update at acceptance. After
// reset the block takes no beats while the bank RAM (one entry per cycle) is filled with 0xFF and the flat RAM with 0.
module paged_memory_bus_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [3:0]  in_palette_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_palette_colour,
  output logic [7:0]  out_screen_start_high,
  output logic [7:0]  out_screen_start_low,
  output logic [3:0]  out_selected_bank
);

  logic       paging_enable_r;
  logic [3:0] bank_select_r;
  logic [3:0] palette_r [16];
  logic [4:0] disp_sel_r;
  logic [7:0] start_high_r;
  logic [7:0] start_low_r;

  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [3:0] s1_pidx_r;

  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic [3:0] out_palette_colour_r;
  logic [7:0] out_start_high_r;
  logic [7:0] out_start_low_r;
  logic [3:0] out_bank_r;

  logic               accept;
  logic               s1_move;
  logic               in_win;
  logic               pg_win;
  logic               pg_bank_sel;
  logic               side_wr;
  logic               clr_busy;
  logic [7:0]         mem_rdata;
  pmbd_pkg::mem_req_t mem_req;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || !out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign in_win      = (in_address[15:14] == pmbd_pkg::WIN_TAG);
  assign pg_win      = paging_enable_r && in_win;
  assign pg_bank_sel = paging_enable_r && ((in_address == pmbd_pkg::ADDR_BANK_SEL_A) ||
                                           (in_address == pmbd_pkg::ADDR_BANK_SEL_B));
  assign side_wr     = accept && (in_mode == pmbd_pkg::MODE_WRITE) && !pg_win && !pg_bank_sel;

  always_comb begin
    mem_req.rd_en     = accept && (in_mode == pmbd_pkg::MODE_READ);
    mem_req.sel_bank  = pg_win;
    mem_req.wr_main   = accept && (in_mode == pmbd_pkg::MODE_WRITE) && !pg_win;
    mem_req.wr_bank   = accept && (in_mode == pmbd_pkg::MODE_WRITE) && pg_win;
    mem_req.main_addr = in_address;
    mem_req.bank_addr = {bank_select_r, in_address[pmbd_pkg::WIN_AW-1:0]};
    mem_req.wdata     = in_write_data;
  end

  pmbd_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rdata    (mem_rdata),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_enable_r <= 1'b0;
      bank_select_r   <= '0;
      disp_sel_r      <= '0;
      start_high_r    <= '0;
      start_low_r     <= '0;
      for (int i = 0; i < 16; i++) begin
        palette_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        paging_enable_r <= cfg_wdata;
      end
      if (accept && (in_mode == pmbd_pkg::MODE_WRITE) && pg_bank_sel) begin
        bank_select_r <= in_write_data[3:0];
      end
      if (side_wr && (in_address == pmbd_pkg::ADDR_PALETTE)) begin
        palette_r[~in_write_data[7:4]] <= in_write_data[3:0];
      end
      if (side_wr && (in_address == pmbd_pkg::ADDR_DISP_SEL)) begin
        disp_sel_r <= in_write_data[4:0];
      end
      if (side_wr && (in_address == pmbd_pkg::ADDR_DISP_DATA)) begin
        if (disp_sel_r == pmbd_pkg::DISP_REG_START_HIGH) begin
          start_high_r <= in_write_data;
        end else if (disp_sel_r == pmbd_pkg::DISP_REG_START_LOW) begin
          start_low_r <= in_write_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_mode;
      s1_pidx_r <= in_palette_index;
    end
  end

  // snapshot taken before the next beat's updates land
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_read_data_r      <= (s1_mode_r == pmbd_pkg::MODE_WRITE) ? 8'h00 : mem_rdata;
      out_palette_colour_r <= palette_r[s1_pidx_r];
      out_start_high_r     <= start_high_r;
      out_start_low_r      <= start_low_r;
      out_bank_r           <= bank_select_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_read_data_r;
  assign out_palette_colour    = out_palette_colour_r;
  assign out_screen_start_high = out_start_high_r;
  assign out_screen_start_low  = out_start_low_r;
  assign out_selected_bank     = out_bank_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept)
    else $error("beat accepted during memory clear");

  a_bank_sel_update: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == pmbd_pkg::MODE_WRITE) && pg_bank_sel)
      |=> (bank_select_r == $past(in_write_data[3:0])))
    else $error("bank select not loaded");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == pmbd_pkg::MODE_READ) && !cfg_we)
      |=> ($stable(bank_select_r) && $stable(disp_sel_r) && $stable(start_high_r) &&
           $stable(start_low_r)))
    else $error("read access changed state");

  a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending beat did not reach empty output");

endmodule

// File: rtl/core/pmbd_mem.sv
module pmbd_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  pmbd_pkg::mem_req_t req,
  output logic [7:0]         rdata,
  output logic               clr_busy
);

  logic [7:0] main_mem [pmbd_pkg::MAIN_DEPTH];
  logic [7:0] bank_mem [pmbd_pkg::BANK_DEPTH];

  logic                         clr_busy_r;
  logic [pmbd_pkg::BANK_AW-1:0] clr_addr_r;
  logic [7:0]                   main_q_r;
  logic [7:0]                   bank_q_r;
  logic                         sel_bank_r;

  // post-reset sweep; both arrays cleared in parallel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      main_mem[clr_addr_r[pmbd_pkg::MAIN_AW-1:0]] <= pmbd_pkg::MAIN_INIT;
      bank_mem[clr_addr_r] <= pmbd_pkg::BANK_INIT;
    end else begin
      if (req.wr_main) begin
        main_mem[req.main_addr] <= req.wdata;
      end
      if (req.wr_bank) begin
        bank_mem[req.bank_addr] <= req.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      main_q_r   <= main_mem[req.main_addr];
      bank_q_r   <= bank_mem[req.bank_addr];
      sel_bank_r <= req.sel_bank;
    end
  end

  assign rdata    = sel_bank_r ? bank_q_r : main_q_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: tb/pmbd_bus_checker.sv
module pmbd_bus_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [3:0]  in_palette_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic [3:0]  out_palette_colour,
  input  logic [7:0]  out_screen_start_high,
  input  logic [7:0]  out_screen_start_low,
  input  logic [3:0]  out_selected_bank,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] colour;
    logic [7:0] start_high;
    logic [7:0] start_low;
    logic [3:0] bank;
  } bus_result_t;

  logic [7:0]                  flat_ram [pmbd_pkg::MAIN_DEPTH];
  logic [7:0]                  bank_ram [pmbd_pkg::BANK_DEPTH];
  logic [pmbd_pkg::BANK_W-1:0] bank_sel;
  logic [3:0]                  palette [16];
  logic [4:0]                  disp_sel;
  logic [7:0]                  start_high;
  logic [7:0]                  start_low;
  logic                        paging_on;

  bus_result_t expected_beats [$];

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %0s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      report_mismatch($sformatf("%0s expected %0h got %0h", name, exp_v, got_v));
    end
  endtask

  function automatic bus_result_t decode_access(input logic mode, input logic [15:0] addr,
                                                input logic [7:0] data, input logic [3:0] pidx);
    bus_result_t r;
    logic        in_win;
    logic [pmbd_pkg::BANK_AW-1:0] baddr;
    in_win = paging_on && (addr[15:14] == pmbd_pkg::WIN_TAG);
    baddr  = {bank_sel, addr[pmbd_pkg::WIN_AW-1:0]};
    r.read_data = 8'h00;
    if (mode == pmbd_pkg::MODE_WRITE) begin
      if (paging_on && (addr == pmbd_pkg::ADDR_BANK_SEL_A ||
                        addr == pmbd_pkg::ADDR_BANK_SEL_B)) begin
        bank_sel = data[3:0];
        flat_ram[addr] = data;
      end else if (in_win) begin
        bank_ram[baddr] = data;
      end else begin
        if (addr == pmbd_pkg::ADDR_PALETTE) palette[~data[7:4]] = data[3:0];
        if (addr == pmbd_pkg::ADDR_DISP_SEL) disp_sel = data[4:0];
        if (addr == pmbd_pkg::ADDR_DISP_DATA) begin
          if (disp_sel == pmbd_pkg::DISP_REG_START_HIGH) start_high = data;
          else if (disp_sel == pmbd_pkg::DISP_REG_START_LOW) start_low = data;
        end
        flat_ram[addr] = data;
      end
    end else begin
      r.read_data = in_win ? bank_ram[baddr] : flat_ram[addr];
    end
    r.colour     = palette[pidx];
    r.start_high = start_high;
    r.start_low  = start_low;
    r.bank       = bank_sel;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_result_t exp_r;
    if (!rst_n) begin
      fail_count = 0;
      paging_on  = 1'b0;
      bank_sel   = '0;
      disp_sel   = '0;
      start_high = '0;
      start_low  = '0;
      for (int i = 0; i < 16; i++) palette[i] = 4'h0;
      for (int i = 0; i < pmbd_pkg::MAIN_DEPTH; i++) flat_ram[i] = pmbd_pkg::MAIN_INIT;
      for (int i = 0; i < pmbd_pkg::BANK_DEPTH; i++) bank_ram[i] = pmbd_pkg::BANK_INIT;
      expected_beats.delete();
    end else begin
      if (cfg_we) paging_on = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_r = expected_beats.pop_front();
          check_field("read_data", int'(exp_r.read_data), int'(out_read_data));
          check_field("palette_colour", int'(exp_r.colour), int'(out_palette_colour));
          check_field("screen_start_high", int'(exp_r.start_high),
                      int'(out_screen_start_high));
          check_field("screen_start_low", int'(exp_r.start_low),
                      int'(out_screen_start_low));
          check_field("selected_bank", int'(exp_r.bank), int'(out_selected_bank));
        end
      end
      if (in_valid && in_ready) begin
        expected_beats.push_back(decode_access(in_mode, in_address, in_write_data,
                                               in_palette_index));
      end
    end
    pending <= expected_beats.size();
  end

endmodule

// File: tb/tb.sv
module tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic [3:0]  in_palette_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic [3:0]  out_palette_colour;
  logic [7:0]  out_screen_start_high;
  logic [7:0]  out_screen_start_low;
  logic [3:0]  out_selected_bank;
  int          fail_count;
  int          pending;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_cycles   = 0;
  int in_idle_tab [4] = '{0, 70, 0, 31};
  int out_stall_tab [4] = '{0, 0, 70, 31};

  paged_memory_bus_decoder_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_palette_index      (in_palette_index),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_data         (out_read_data),
    .out_palette_colour    (out_palette_colour),
    .out_screen_start_high (out_screen_start_high),
    .out_screen_start_low  (out_screen_start_low),
    .out_selected_bank     (out_selected_bank)
  );

  pmbd_bus_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_palette_index      (in_palette_index),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_data         (out_read_data),
    .out_palette_colour    (out_palette_colour),
    .out_screen_start_high (out_screen_start_high),
    .out_screen_start_low  (out_screen_start_low),
    .out_selected_bank     (out_selected_bank),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, or a counted hold-off when requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  task automatic write_paging(input logic en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_beat(input logic m, input logic [15:0] a, input logic [7:0] d,
                           input logic [3:0] p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_address       <= a;
    in_write_data    <= d;
    in_palette_index <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [13:0] gen_win_offset();
    case ($urandom_range(3))
      0, 1:    return 14'($urandom_range(15));
      2:       return 14'h3FF0 | 14'($urandom_range(15));
      default: return 14'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] gen_address();
    case ($urandom_range(9))
      0:       return pmbd_pkg::ADDR_BANK_SEL_A;
      1:       return pmbd_pkg::ADDR_BANK_SEL_B;
      2:       return pmbd_pkg::ADDR_PALETTE;
      3:       return pmbd_pkg::ADDR_DISP_SEL;
      4:       return pmbd_pkg::ADDR_DISP_DATA;
      5, 6:    return {pmbd_pkg::WIN_TAG, gen_win_offset()};
      7:       return 16'($urandom());
      8:       return 16'($urandom_range(15));
      default: begin
        case ($urandom_range(3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hBFFF;
          default: return 16'hC000;
        endcase
      end
    endcase
  endfunction

  task automatic run_random(input int n);
    int sent;
    int kind;
    int burst;
    logic [4:0] sel;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        sel = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'(12 + $urandom_range(1));
        send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_SEL, {3'($urandom()), sel},
                  4'($urandom()));
        send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_DATA, 8'($urandom()),
                  4'($urandom()));
        sent += 2;
      end else if (kind < 4) begin
        send_beat(pmbd_pkg::MODE_WRITE,
                  $urandom_range(1) ? pmbd_pkg::ADDR_BANK_SEL_A : pmbd_pkg::ADDR_BANK_SEL_B,
                  8'($urandom()), 4'($urandom()));
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          send_beat(1'($urandom()), {pmbd_pkg::WIN_TAG, gen_win_offset()}, 8'($urandom()),
                    4'($urandom()));
        end
        sent += 1 + burst;
      end else if (kind == 4) begin
        send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_PALETTE, 8'($urandom()),
                  4'($urandom()));
        sent++;
      end else begin
        send_beat(1'($urandom()), gen_address(), 8'($urandom()), 4'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= pmbd_pkg::MODE_READ;
    in_address       <= '0;
    in_write_data    <= '0;
    in_palette_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // paging off: flat map everywhere, palette and display regs
    write_paging(1'b0);
    send_beat(pmbd_pkg::MODE_READ,  16'h0000,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_BANK_SEL_A, 8'hA5, 4'hF);
    send_beat(pmbd_pkg::MODE_READ,  pmbd_pkg::ADDR_BANK_SEL_A, 8'hFF, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'h8000,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, 16'h8000,                 8'h5A, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'h8000,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_PALETTE,    8'h0F, 4'hF);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_PALETTE,    8'hF0, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_SEL,   8'hEC, 4'hF);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_DATA,  8'hFF, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_SEL,   8'h0D, 4'hF);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_DATA,  8'h81, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_SEL,   8'h1F, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_DISP_DATA,  8'h00, 4'h0);
    wait_drained();

    // paging on: bank select, window edges
    write_paging(1'b1);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_BANK_SEL_B, 8'hFF, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'hBFFF,                 8'h00, 4'hF);
    send_beat(pmbd_pkg::MODE_WRITE, 16'hBFFF,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'hBFFF,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, pmbd_pkg::ADDR_BANK_SEL_A, 8'hF0, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'h8000,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'h7FFF,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  16'hC000,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_WRITE, 16'hFFFF,                 8'hFF, 4'hF);
    send_beat(pmbd_pkg::MODE_READ,  16'hFFFF,                 8'h00, 4'h0);
    send_beat(pmbd_pkg::MODE_READ,  pmbd_pkg::ADDR_BANK_SEL_B, 8'h00, 4'h0);
    wait_drained();

    // long receiver hold-off with the sender offering back to back
    hold_cycles = 300;
    run_random(40);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      in_idle_pct   = in_idle_tab[ph % 4];
      out_stall_pct = out_stall_tab[ph % 4];
      write_paging((ph % 3) != 1);
      run_random(180);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
